>>> src/hcbp_pkg.sv
// hcbp_pkg: shared types and constants of the huffman code bit packer
// no dependencies; imported by every module of the block

package hcbp_pkg;

  // field widths
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned SYM_FIELD_W = 8;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PEND_W      = 7;
  localparam int unsigned PCNT_W      = 3;
  localparam int unsigned BURST_BYTES = 4;
  localparam int unsigned BCNT_W      = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  // registered table lookup handed to the packer
  typedef struct packed {
    logic              valid;
    logic              flush;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } hcbp_lookup_t;

  // group of completed bytes handed to the output buffer, first byte in the top
  typedef struct packed {
    logic                           load;
    logic [BCNT_W-1:0]              count;
    logic [BURST_BYTES*BYTE_W-1:0]  bytes;
  } hcbp_burst_t;

endpackage

>>> src/hcbp_table.sv
// hcbp_table: code word and code length tables with input register stage
// depends on hcbp_pkg; the lookup register feeds hcbp_packer

module hcbp_table
  import hcbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CMD_W-1:0]       command_i,
  input  logic [SYM_FIELD_W-1:0] symbol_i,
  input  logic [WORD_W-1:0]      code_bits_i,
  input  logic [LEN_W-1:0]       code_length_i,
  input  logic                   take_i,
  output hcbp_lookup_t           lookup_o
);

  localparam int unsigned SYM_W   = $clog2(SYMBOL_COUNT);
  localparam int unsigned LEN_CAP = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;

  logic [WORD_W-1:0]     word_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]      len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] written_q;

  logic              s1_valid_q;
  logic              s1_flush_q;
  logic              s1_hit_q;
  logic [WORD_W-1:0] word_rd_q;
  logic [LEN_W-1:0]  len_rd_q;

  logic             accept;
  logic             in_range;
  logic [SYM_W-1:0] idx;
  logic             is_load;
  logic             is_encode;
  logic             is_flush;
  logic [LEN_W-1:0] len_sat;

  // input handshake: the lookup register moves on when the packer takes it
  assign in_stall_o = s1_valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_range  = {1'b0, symbol_i} < 9'(SYMBOL_COUNT);
  assign idx       = symbol_i[SYM_W-1:0];
  assign is_load   = command_i == CMD_LOAD;
  assign is_encode = command_i == CMD_ENCODE;
  assign is_flush  = command_i == CMD_FLUSH;

  // saturate loaded length
  assign len_sat = (code_length_i > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_length_i;

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (accept && is_load && in_range) begin
      word_mem[idx] <= code_bits_i;
      len_mem[idx]  <= len_sat;
    end
    if (accept) begin
      word_rd_q <= word_mem[idx];
      len_rd_q  <= len_mem[idx];
    end
  end

  // per-entry written flags, lookup control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
      s1_hit_q   <= 1'b0;
    end else begin
      if (accept && is_load && in_range) begin
        written_q[idx] <= 1'b1;
      end
      if (accept) begin
        s1_valid_q <= is_encode || is_flush;
        s1_flush_q <= is_flush;
        s1_hit_q   <= is_encode && in_range && written_q[idx];
      end else if (take_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // an entry never written, or a miss, reads as an empty code
  assign lookup_o.valid = s1_valid_q;
  assign lookup_o.flush = s1_flush_q;
  assign lookup_o.word  = word_rd_q;
  assign lookup_o.len   = s1_hit_q ? len_rd_q : '0;

  // stall only while a lookup waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty lookup stage");

  // a load in range marks its entry written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_load && in_range) |=> written_q[$past(idx)])
    else $error("loaded entry not marked written");

endmodule

>>> src/hcbp_packer.sv
// hcbp_packer: joins looked-up code bits with the pending partial byte
// depends on hcbp_pkg; takes hcbp_table lookups, feeds hcbp_emit

module hcbp_packer
  import hcbp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  hcbp_lookup_t lookup_i,
  input  logic         emit_free_i,
  output logic         take_o,
  output hcbp_burst_t  burst_o
);

  localparam int unsigned STREAM_W = PEND_W + WORD_W;
  localparam int unsigned BURST_W  = BURST_BYTES * BYTE_W;

  logic [PEND_W-1:0] pend_q, pend_d;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d;

  logic [LEN_W-1:0]    total;
  logic [WORD_W:0]     hi_mask;
  logic [WORD_W-1:0]   masked;
  logic [STREAM_W-1:0] stream;
  logic [STREAM_W-1:0] shifted;
  logic [PCNT_W-1:0]   rem;
  logic [BCNT_W-1:0]   nbytes;
  logic [BCNT_W-1:0]   gap;
  logic [BURST_W-1:0]  aligned;
  logic [BYTE_W-1:0]   flush_byte;
  logic [3:0]          flush_shift;
  logic                has_bytes;

  // append code bits below the pending bits
  always_comb begin
    total   = LEN_W'(pcnt_q) + lookup_i.len;
    hi_mask = {(WORD_W+1){1'b1}} << lookup_i.len;
    masked  = lookup_i.word & ~hi_mask[WORD_W-1:0];
    stream  = ({{WORD_W{1'b0}}, pend_q} << lookup_i.len) | {{PEND_W{1'b0}}, masked};
    rem     = total[PCNT_W-1:0];
    nbytes  = BCNT_W'(total[LEN_W-1:PCNT_W]);
    shifted = stream >> rem;
    gap     = BCNT_W'(BURST_BYTES) - nbytes;
    aligned = shifted[BURST_W-1:0] << {gap, 3'b000};
  end

  // flush pads the partial byte with zeros on the right
  assign flush_shift = 4'(BYTE_W) - {1'b0, pcnt_q};
  assign flush_byte  = BYTE_W'({1'b0, pend_q} << flush_shift);

  assign has_bytes = lookup_i.flush ? (pcnt_q != '0) : (nbytes != '0);
  assign take_o    = lookup_i.valid && (!has_bytes || emit_free_i);

  assign burst_o.load  = take_o && has_bytes;
  assign burst_o.count = lookup_i.flush ? BCNT_W'(1) : nbytes;
  assign burst_o.bytes = lookup_i.flush ? {flush_byte, {(BURST_W-BYTE_W){1'b0}}} : aligned;

  // next pending state
  always_comb begin
    pend_d = pend_q;
    pcnt_d = pcnt_q;
    if (take_o) begin
      if (lookup_i.flush) begin
        pend_d = '0;
        pcnt_d = '0;
      end else begin
        pend_d = stream[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
        pcnt_d = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pcnt_q <= '0;
    end else begin
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
    end
  end

  // pending bits above the count stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni) (pend_q >> pcnt_q) == '0)
    else $error("stray pending bits above count");

endmodule

>>> src/hcbp_emit.sv
// hcbp_emit: output byte buffer, one beat per cycle while the output is not stalled, first byte first
// depends on hcbp_pkg; loaded by hcbp_packer

module hcbp_emit
  import hcbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcbp_burst_t       burst_i,
  output logic              emit_free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_of_run_o
);

  localparam int unsigned BURST_W = BURST_BYTES * BYTE_W;

  logic [BURST_W-1:0] buf_q, buf_d;
  logic [BCNT_W-1:0]  cnt_q, cnt_d;
  logic               out_fire;

  assign out_valid_o   = cnt_q != '0;
  assign out_byte_o    = buf_q[BURST_W-1 -: BYTE_W];
  assign last_of_run_o = cnt_q == BCNT_W'(1);
  assign out_fire      = out_valid_o && !out_stall_i;
  assign emit_free_o   = (cnt_q == '0) || (last_of_run_o && out_fire);

  // load a new group or shift out one byte
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (burst_i.load) begin
      buf_d = burst_i.bytes;
      cnt_d = burst_i.count;
    end else if (out_fire) begin
      buf_d = buf_q << BYTE_W;
      cnt_d = cnt_q - BCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // buffer never holds more than one group
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= BCNT_W'(BURST_BYTES))
    else $error("output buffer count overflow");

  // a group is only loaded once the previous one is gone
  assert property (@(posedge clk_i) disable iff (!rst_ni) burst_i.load |-> emit_free_o)
    else $error("output group overwritten");

endmodule

>>> src/huffman_code_bit_packer_top.sv
// path: an accepted item is registered in the table lookup stage; its completed bytes then
//   pass through the packer into the output byte buffer, whose top byte drives the output
// throughput: one item per cycle while each gives at most one byte and the output is not
//   stalled; an item giving more bytes holds the one-byte output port until all (up to 4) are out
// reset: control, pending bits and code length valid flags clear at once;
//   code word contents stay undefined until loaded
// depends on hcbp_pkg, hcbp_table, hcbp_packer, hcbp_emit

module huffman_code_bit_packer_top
  import hcbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned SYMBOL_COUNT = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [CMD_W-1:0]       command_i,
  input  logic [SYM_FIELD_W-1:0] symbol_i,
  input  logic [WORD_W-1:0]      code_bits_i,
  input  logic [LEN_W-1:0]       code_length_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic                   last_of_run_o
);

  hcbp_lookup_t lookup;
  hcbp_burst_t  burst;
  logic         take;
  logic         emit_free;

  // table lookup stage
  hcbp_table #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .symbol_i     (symbol_i),
    .code_bits_i  (code_bits_i),
    .code_length_i(code_length_i),
    .take_i       (take),
    .lookup_o     (lookup)
  );

  // bit accumulation
  hcbp_packer u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lookup_i   (lookup),
    .emit_free_i(emit_free),
    .take_o     (take),
    .burst_o    (burst)
  );

  // byte output buffer
  hcbp_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .burst_i      (burst),
    .emit_free_o  (emit_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule
